[rtl/assert_macros.svh]
// assertion macros for the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is high
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// clocked property checked during reset as well
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");

`endif

[rtl/ppps_pkg.sv]
// types and constants for the particle pool physics step block
// no dependencies
package ppps_pkg;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_SPAWN = 2'd1,
      CMD_START = 2'd2,
      CMD_STOP  = 2'd3
   } cmd_type;

   localparam logic [2:0] CSR_ACCEL_X     = 3'd0;
   localparam logic [2:0] CSR_ACCEL_Y     = 3'd1;
   localparam logic [2:0] CSR_COLOR_BEGIN = 3'd2;
   localparam logic [2:0] CSR_COLOR_FINAL = 3'd3;
   localparam logic [2:0] CSR_SIZE_BEGIN  = 3'd4;
   localparam logic [2:0] CSR_SIZE_FINAL  = 3'd5;
   localparam logic [2:0] CSR_EMIT_RATE   = 3'd6;

   localparam logic [15:0] RST_ACCEL_X     = 16'd0;
   localparam logic [15:0] RST_ACCEL_Y     = 16'd10;
   localparam logic [7:0]  RST_COLOR_BEGIN = 8'd1;
   localparam logic [7:0]  RST_COLOR_FINAL = 8'd0;
   localparam logic [7:0]  RST_SIZE_BEGIN  = 8'd1;
   localparam logic [7:0]  RST_SIZE_FINAL  = 8'd1;
   localparam logic [15:0] RST_EMIT_RATE   = 16'd5;

   // quotient bits of one interpolation division
   localparam int DIV_STEPS = 8;

   typedef struct packed {
      logic [23:0] pos_x;
      logic [23:0] pos_y;
      logic [15:0] vel_x;
      logic [15:0] vel_y;
      logic [15:0] life;
      logic [15:0] total;
      logic [7:0]  color;
      logic [7:0]  size;
   } entry_type;

   typedef struct packed {
      logic tick_start;
      logic do_spawn;
      logic do_start;
      logic do_stop;
      logic rd_en;
      logic rd_sel_out;
      logic calc;
      logic skip;
      logic mul;
      logic div_step;
      logic wr_back;
      logic commit;
      logic load_particle;
      logic load_summary;
   } dp_cmd_type;

   typedef struct packed {
      logic i_end;
      logic j_end;
      logic survive;
      logic out_free;
   } dp_status_type;

endpackage

[rtl/ppps_ram.sv]
// generic single write, single read ram with registered read data
// no dependencies
module ppps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   parameter int AW = 5
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/ppps_div.sv]
// restoring divider, one quotient bit per step, quotient known to fit 8 bits
// depends on ppps_pkg
module ppps_div
   import ppps_pkg::*;
(
   input  logic        clock,
   input  logic        load,
   input  logic        step,
   input  logic [23:0] dividend,
   input  logic [15:0] divisor,
   output logic [7:0]  quotient
);
   logic [15:0] rem_ff, rem_in;
   logic [7:0]  low_ff, low_in;
   logic [7:0]  q_ff, q_in;
   logic [16:0] trial;

   always_comb begin
      rem_in = rem_ff;
      low_in = low_ff;
      q_in   = q_ff;
      trial  = {rem_ff, low_ff[7]};
      if (load) begin
         rem_in = dividend[23:8];
         low_in = dividend[7:0];
         q_in   = 8'd0;
      end else if (step) begin
         low_in = {low_ff[6:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in = 16'(trial - {1'b0, divisor});
            q_in   = {q_ff[6:0], 1'b1};
         end else begin
            rem_in = trial[15:0];
            q_in   = {q_ff[6:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
      q_ff   <= q_in;
   end

   assign quotient = q_ff;
endmodule

[rtl/ppps_datapath.sv]
// datapath: config registers, pool ram, physics update, interpolation, output register
// depends on ppps_pkg, ppps_ram, ppps_div
module ppps_datapath
   import ppps_pkg::*;
#(
   parameter int POOL_DEPTH = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  logic [79:0]   req_tdata,
   input  logic          csr_we,
   input  logic [2:0]    csr_index,
   input  logic [15:0]   csr_wdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [63:0]   rsp_tdata,
   output logic [0:0]    rsp_tuser,
   output logic          rsp_tlast
);
   localparam int CW = $clog2(POOL_DEPTH + 1);
   localparam int AW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int EW = $bits(entry_type);

   // config
   logic [15:0] accel_x_ff, accel_y_ff, emit_rate_ff;
   logic [7:0]  color_begin_ff, color_final_ff, size_begin_ff, size_final_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_x_ff     <= RST_ACCEL_X;
         accel_y_ff     <= RST_ACCEL_Y;
         color_begin_ff <= RST_COLOR_BEGIN;
         color_final_ff <= RST_COLOR_FINAL;
         size_begin_ff  <= RST_SIZE_BEGIN;
         size_final_ff  <= RST_SIZE_FINAL;
         emit_rate_ff   <= RST_EMIT_RATE;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ACCEL_X:     accel_x_ff     <= csr_wdata;
            CSR_ACCEL_Y:     accel_y_ff     <= csr_wdata;
            CSR_COLOR_BEGIN: color_begin_ff <= csr_wdata[7:0];
            CSR_COLOR_FINAL: color_final_ff <= csr_wdata[7:0];
            CSR_SIZE_BEGIN:  size_begin_ff  <= csr_wdata[7:0];
            CSR_SIZE_FINAL:  size_final_ff  <= csr_wdata[7:0];
            CSR_EMIT_RATE:   emit_rate_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // control state
   logic [CW-1:0] count_ff, count_in, i_ff, i_in, w_ff, w_in, j_ff, j_in;
   logic [16:0]   emit_acc_ff, emit_acc_in;
   logic          emitting_ff, emitting_in;
   logic [8:0]    units_ff, units_in;
   logic [5:0]    req_ff, req_in;
   logic          accepted_ff, accepted_in;
   logic          full;
   logic [16:0]   emit_sum;
   logic [CW-1:0] free_slots;

   assign full       = (count_ff == CW'(POOL_DEPTH));
   assign emit_sum   = emit_acc_ff + {1'b0, emit_rate_ff};
   assign free_slots = CW'(POOL_DEPTH) - w_ff;

   always_comb begin
      count_in    = count_ff;
      i_in        = i_ff;
      w_in        = w_ff;
      j_in        = j_ff;
      emit_acc_in = emit_acc_ff;
      emitting_in = emitting_ff;
      units_in    = units_ff;
      req_in      = req_ff;
      accepted_in = accepted_ff;
      if (cmd.tick_start) begin
         i_in        = '0;
         w_in        = '0;
         accepted_in = 1'b0;
         units_in    = 9'd0;
         if (emitting_ff && emit_rate_ff != 16'd0) begin
            units_in    = emit_sum[16:8];
            emit_acc_in = {9'd0, emit_sum[7:0]};
         end
      end
      if (cmd.do_spawn) begin
         accepted_in = !full;
         req_in      = 6'd0;
         if (!full) begin
            count_in = count_ff + CW'(1);
         end
      end
      if (cmd.do_start) begin
         emitting_in = 1'b1;
         emit_acc_in = 17'd0;
         accepted_in = 1'b0;
         req_in      = 6'd0;
      end
      if (cmd.do_stop) begin
         emitting_in = 1'b0;
         accepted_in = 1'b0;
         req_in      = 6'd0;
      end
      if (cmd.skip) begin
         i_in = i_ff + CW'(1);
      end
      if (cmd.wr_back) begin
         i_in = i_ff + CW'(1);
         w_in = w_ff + CW'(1);
      end
      if (cmd.commit) begin
         count_in = w_ff;
         j_in     = '0;
         req_in   = (units_ff < 9'(free_slots)) ? units_ff[5:0] : 6'(free_slots);
      end
      if (cmd.load_particle) begin
         j_in = j_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         i_ff        <= '0;
         w_ff        <= '0;
         j_ff        <= '0;
         emit_acc_ff <= 17'd0;
         emitting_ff <= 1'b0;
         units_ff    <= 9'd0;
         req_ff      <= 6'd0;
         accepted_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         i_ff        <= i_in;
         w_ff        <= w_in;
         j_ff        <= j_in;
         emit_acc_ff <= emit_acc_in;
         emitting_ff <= emitting_in;
         units_ff    <= units_in;
         req_ff      <= req_in;
         accepted_ff <= accepted_in;
      end
   end

   // pool memory
   entry_type     rd_entry, wr_entry, spawn_entry, upd_entry;
   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [EW-1:0] rd_raw;

   assign spawn_entry = '{
      pos_x: {req_tdata[15:0], 8'd0},
      pos_y: {req_tdata[31:16], 8'd0},
      vel_x: req_tdata[47:32],
      vel_y: req_tdata[63:48],
      life:  req_tdata[79:64],
      total: req_tdata[79:64],
      color: color_begin_ff,
      size:  size_begin_ff
   };

   assign wr_en    = (cmd.do_spawn && !full) || cmd.wr_back;
   assign wr_addr  = cmd.wr_back ? w_ff[AW-1:0] : count_ff[AW-1:0];
   assign wr_entry = cmd.wr_back ? upd_entry : spawn_entry;
   assign rd_addr  = cmd.rd_sel_out ? j_ff[AW-1:0] : i_ff[AW-1:0];
   assign rd_entry = entry_type'(rd_raw);

   ppps_ram #(.WIDTH(EW), .DEPTH(POOL_DEPTH), .AW(AW)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (EW'(wr_entry)),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   // euler step with saturation
   logic [16:0] vx_sum, vy_sum;
   logic [15:0] vx_sat, vy_sat;
   logic [24:0] px_sum, py_sum;
   logic [23:0] px_sat, py_sat;
   logic [15:0] life_dec;

   assign vx_sum = {rd_entry.vel_x[15], rd_entry.vel_x} + {accel_x_ff[15], accel_x_ff};
   assign vy_sum = {rd_entry.vel_y[15], rd_entry.vel_y} + {accel_y_ff[15], accel_y_ff};
   assign vx_sat = (vx_sum[16] != vx_sum[15]) ? (vx_sum[16] ? 16'h8000 : 16'h7FFF)
                                              : vx_sum[15:0];
   assign vy_sat = (vy_sum[16] != vy_sum[15]) ? (vy_sum[16] ? 16'h8000 : 16'h7FFF)
                                              : vy_sum[15:0];
   assign px_sum = {rd_entry.pos_x[23], rd_entry.pos_x} + {{9{vx_sat[15]}}, vx_sat};
   assign py_sum = {rd_entry.pos_y[23], rd_entry.pos_y} + {{9{vy_sat[15]}}, vy_sat};
   assign px_sat = (px_sum[24] != px_sum[23]) ? (px_sum[24] ? 24'h800000 : 24'h7FFFFF)
                                              : px_sum[23:0];
   assign py_sat = (py_sum[24] != py_sum[23]) ? (py_sum[24] ? 24'h800000 : 24'h7FFFFF)
                                              : py_sum[23:0];
   assign life_dec = rd_entry.life - 16'd1;

   entry_type   work_ff;
   logic [15:0] elapsed_ff;

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         work_ff.pos_x <= px_sat;
         work_ff.pos_y <= py_sat;
         work_ff.vel_x <= vx_sat;
         work_ff.vel_y <= vy_sat;
         work_ff.life  <= life_dec;
         work_ff.total <= rd_entry.total;
         work_ff.color <= rd_entry.color;
         work_ff.size  <= rd_entry.size;
         elapsed_ff    <= (rd_entry.total >= life_dec) ? (rd_entry.total - life_dec) : 16'd0;
      end
   end

   // interpolation: begin + (range * elapsed) / total, truncated toward zero
   logic [8:0]  c_range, s_range;
   logic [7:0]  c_mag, s_mag;
   logic        c_neg_ff, s_neg_ff;
   logic [23:0] c_prod, s_prod;
   logic [7:0]  c_q, s_q;
   logic        c_keep, s_keep;
   logic [7:0]  c_new, s_new;

   assign c_range = {1'b0, color_final_ff} - {1'b0, color_begin_ff};
   assign s_range = {1'b0, size_final_ff} - {1'b0, size_begin_ff};
   assign c_mag   = c_range[8] ? 8'(-c_range) : c_range[7:0];
   assign s_mag   = s_range[8] ? 8'(-s_range) : s_range[7:0];
   assign c_prod  = {16'd0, c_mag} * {8'd0, elapsed_ff};
   assign s_prod  = {16'd0, s_mag} * {8'd0, elapsed_ff};

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         c_neg_ff <= c_range[8];
         s_neg_ff <= s_range[8];
      end
   end

   ppps_div u_div_color (
      .clock    (clock),
      .load     (cmd.mul),
      .step     (cmd.div_step),
      .dividend (c_prod),
      .divisor  (work_ff.total),
      .quotient (c_q)
   );

   ppps_div u_div_size (
      .clock    (clock),
      .load     (cmd.mul),
      .step     (cmd.div_step),
      .dividend (s_prod),
      .divisor  (work_ff.total),
      .quotient (s_q)
   );

   assign c_keep = (color_begin_ff == color_final_ff) || (work_ff.total == 16'd0);
   assign s_keep = (size_begin_ff == size_final_ff) || (work_ff.total == 16'd0);
   assign c_new  = c_keep ? work_ff.color
                          : (c_neg_ff ? color_begin_ff - c_q : color_begin_ff + c_q);
   assign s_new  = s_keep ? work_ff.size
                          : (s_neg_ff ? size_begin_ff - s_q : size_begin_ff + s_q);

   always_comb begin
      upd_entry       = work_ff;
      upd_entry.color = c_new;
      upd_entry.size  = s_new;
   end

   // output register
   logic [23:0] px_bias, py_bias;
   logic        out_valid_ff, out_valid_in;
   logic [63:0] out_data_ff, out_data_in;
   logic        out_kind_ff, out_kind_in;
   logic        out_free;

   assign px_bias  = rd_entry.pos_x + (rd_entry.pos_x[23] ? 24'd255 : 24'd0);
   assign py_bias  = rd_entry.pos_y + (rd_entry.pos_y[23] ? 24'd255 : 24'd0);
   assign out_free = !out_valid_ff || rsp_tready;

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      out_data_in  = out_data_ff;
      out_kind_in  = out_kind_ff;
      if (cmd.load_particle) begin
         out_valid_in = 1'b1;
         out_kind_in  = 1'b0;
         out_data_in  = {3'd0, 1'b0, req_ff, 6'(count_ff), rd_entry.size, rd_entry.color,
                         py_bias[23:8], px_bias[23:8]};
      end else if (cmd.load_summary) begin
         out_valid_in = 1'b1;
         out_kind_in  = 1'b1;
         out_data_in  = {3'd0, accepted_ff, req_ff, 6'(count_ff), 8'd0, 8'd0, 16'd0, 16'd0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      out_data_ff <= out_data_in;
      out_kind_ff <= out_kind_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tlast  = out_kind_ff;

   assign status.i_end    = (i_ff == count_ff);
   assign status.j_end    = (j_ff == count_ff);
   assign status.survive  = (rd_entry.life > 16'd1);
   assign status.out_free = out_free;
endmodule

[rtl/ppps_ctrl.sv]
// controller state machine sequencing commands, tick pass and output pass
// depends on ppps_pkg
module ppps_ctrl
   import ppps_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [1:0]    req_tuser,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);
   localparam int DCW = $clog2(DIV_STEPS);

   typedef enum logic [9:0] {
      S_IDLE = 10'b00_0000_0001,
      S_RD   = 10'b00_0000_0010,
      S_CALC = 10'b00_0000_0100,
      S_MUL  = 10'b00_0000_1000,
      S_DIV  = 10'b00_0001_0000,
      S_WR   = 10'b00_0010_0000,
      S_ORD  = 10'b00_0100_0000,
      S_OVAL = 10'b00_1000_0000,
      S_SUM  = 10'b01_0000_0000,
      S_HOLD = 10'b10_0000_0000
   } state_type;

   state_type      state_ff, state_in;
   logic [DCW-1:0] dcnt_ff, dcnt_in;
   cmd_type        op;

   assign op         = cmd_type'(req_tuser);
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      dcnt_in  = dcnt_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               case (op)
                  CMD_TICK: begin
                     cmd.tick_start = 1'b1;
                     state_in       = S_RD;
                  end
                  CMD_SPAWN: begin
                     cmd.do_spawn = 1'b1;
                     state_in     = S_SUM;
                  end
                  CMD_START: begin
                     cmd.do_start = 1'b1;
                     state_in     = S_SUM;
                  end
                  CMD_STOP: begin
                     cmd.do_stop = 1'b1;
                     state_in    = S_SUM;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_RD: begin
            if (status.i_end) begin
               cmd.commit = 1'b1;
               state_in   = S_ORD;
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_CALC;
            end
         end
         S_CALC: begin
            cmd.calc = 1'b1;
            if (status.survive) begin
               state_in = S_MUL;
            end else begin
               cmd.skip = 1'b1;
               state_in = S_RD;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            dcnt_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            dcnt_in      = dcnt_ff + DCW'(1);
            if (dcnt_ff == DCW'(DIV_STEPS - 1)) begin
               state_in = S_WR;
            end
         end
         S_WR: begin
            cmd.wr_back = 1'b1;
            state_in    = S_RD;
         end
         S_ORD: begin
            if (status.j_end) begin
               state_in = S_SUM;
            end else begin
               cmd.rd_en      = 1'b1;
               cmd.rd_sel_out = 1'b1;
               state_in       = S_OVAL;
            end
         end
         S_OVAL: begin
            if (status.out_free) begin
               cmd.load_particle = 1'b1;
               state_in          = S_ORD;
            end
         end
         S_SUM: begin
            if (status.out_free) begin
               cmd.load_summary = 1'b1;
               state_in         = S_HOLD;
            end
         end
         S_HOLD: begin
            // summary now in the output register, ready for the next beat
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         dcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         dcnt_ff  <= dcnt_in;
      end
   end
endmodule

[rtl/particle_pool_physics_step.sv]
// particle pool physics step: spawn, emission control and per-tick euler update
// sequence: spawn, start and stop load their summary beat in S_SUM once the output
// register is free, then pass S_HOLD; a tick walks the pool, a survivor going through read,
// update, multiply, 8-step divide and write back, a dead entry through read and update,
// then one output beat per survivor plus summary; one item is taken at a time, in idle only
// reset: synchronous active high, clears pool count, emission state, config defaults
module particle_pool_physics_step
   import ppps_pkg::*;
#(
   parameter int POOL_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   // input beats
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // pos_x, pos_y, vel_x, vel_y, life_ticks
   input  logic [1:0]  req_tuser,   // command
   // result beats
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // pixel_x, pixel_y, color, size, live_count,
                                    // spawn_request, accepted, zero pad
   output logic [0:0]  rsp_tuser,   // kind
   output logic        rsp_tlast,   // last
   // config writes
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   dp_cmd_type    cmd;
   dp_status_type status;

   // sequencer: owns the tick pass, the output pass and the summary beat
   ppps_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .status     (status)
   );

   // pool ram, physics math, interpolation dividers, output register
   ppps_datapath #(.POOL_DEPTH(POOL_DEPTH)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );
endmodule

[rtl/ppps_checker.sv]
// port-level checker for the particle pool physics step, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"
module ppps_checker #(
   parameter int POOL_DEPTH = 32
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [0:0]  rsp_tuser,
   input logic        rsp_tlast
);
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
   `ASSERT_CLK(a_last_is_summary, clock, reset, rsp_tvalid |-> rsp_tlast == rsp_tuser[0])
   `ASSERT_CLK(a_live_bound, clock, reset, rsp_tvalid |-> {1'b0, rsp_tdata[53:48]} + {1'b0, rsp_tdata[59:54]} <= 7'(POOL_DEPTH))
   `ASSERT_CLK(a_record_clean, clock, reset, rsp_tvalid && !rsp_tuser[0] |-> !rsp_tdata[60])
   `ASSERT_CLK_ALWAYS(a_reset_idle, clock, reset |=> !rsp_tvalid)
endmodule

bind particle_pool_physics_step ppps_checker #(.POOL_DEPTH(POOL_DEPTH)) u_checker (.*);

[test/tb_particle_pool_physics_step.sv]
// self-checking bench for particle_pool_physics_step: spawn, emission and euler tick beats
// depends on ppps_pkg and the particle_pool_physics_step rtl
`timescale 1ns / 1ps

module tb_particle_pool_physics_step
   import ppps_pkg::*;
;

   localparam int DEPTH = 32;

   // one result beat, unpacked
   typedef struct {
      logic        kind;
      logic [15:0] pixel_x;
      logic [15:0] pixel_y;
      logic [7:0]  color;
      logic [7:0]  size;
      logic [5:0]  live_count;
      logic [5:0]  spawn_request;
      logic        accepted;
      logic        last;
   } pixel_rec_type;

   // predicts the pool and holds the beats still owed by the block
   class particle_scoreboard;
      logic signed [23:0] pos_x[DEPTH], pos_y[DEPTH];
      logic signed [15:0] vel_x[DEPTH], vel_y[DEPTH];
      logic [15:0]        life_left[DEPTH], life_total[DEPTH];
      logic [7:0]         look_color[DEPTH], look_size[DEPTH];
      int                 pool_count;
      logic [16:0]        emit_acc;
      bit                 emitting;
      logic signed [15:0] accel_x, accel_y;
      logic [7:0]         color_begin, color_final, size_begin, size_final;
      logic [15:0]        emit_rate;
      pixel_rec_type      owed_beats[$];
      int                 errors, beats_checked, ticks, spawns_taken, spawns_dropped;

      function new();
         pool_count  = 0;
         emit_acc    = '0;
         emitting    = 0;
         accel_x     = RST_ACCEL_X;
         accel_y     = RST_ACCEL_Y;
         color_begin = RST_COLOR_BEGIN;
         color_final = RST_COLOR_FINAL;
         size_begin  = RST_SIZE_BEGIN;
         size_final  = RST_SIZE_FINAL;
         emit_rate   = RST_EMIT_RATE;
      endfunction

      function int pending();
         return owed_beats.size();
      endfunction

      function void set_reg(logic [2:0] idx, logic [15:0] v);
         case (idx)
            CSR_ACCEL_X:     accel_x = v;
            CSR_ACCEL_Y:     accel_y = v;
            CSR_COLOR_BEGIN: color_begin = v[7:0];
            CSR_COLOR_FINAL: color_final = v[7:0];
            CSR_SIZE_BEGIN:  size_begin = v[7:0];
            CSR_SIZE_FINAL:  size_final = v[7:0];
            CSR_EMIT_RATE:   emit_rate = v;
            default: ;
         endcase
      endfunction

      function int sat(int v, int lo, int hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      // linear step from begin toward final by elapsed life fraction
      function logic [7:0] interp(logic [7:0] b, logic [7:0] f, int elapsed, int total,
                                  logic [7:0] keep);
         int r;
         if (b == f || total == 0) return keep;
         r = int'(b) + ((int'(f) - int'(b)) * elapsed) / total;
         return r[7:0];
      endfunction

      function void note_input(cmd_type cmd, logic [79:0] d);
         pixel_rec_type r;
         int units, req, w, vx, vy, px, py, lf, tot, elapsed;
         logic [7:0] c, s;
         bit took;
         units = 0;
         req = 0;
         took = 0;
         case (cmd)
            CMD_SPAWN: begin
               if (pool_count < DEPTH) begin
                  pos_x[pool_count]      = {d[15:0], 8'd0};
                  pos_y[pool_count]      = {d[31:16], 8'd0};
                  vel_x[pool_count]      = d[47:32];
                  vel_y[pool_count]      = d[63:48];
                  life_left[pool_count]  = d[79:64];
                  life_total[pool_count] = d[79:64];
                  look_color[pool_count] = color_begin;
                  look_size[pool_count]  = size_begin;
                  pool_count++;
                  took = 1;
                  spawns_taken++;
               end else begin
                  spawns_dropped++;
               end
            end
            CMD_START: begin
               emitting = 1;
               emit_acc = '0;
            end
            CMD_STOP: emitting = 0;
            default: begin
               ticks++;
               if (emitting && emit_rate != 0) begin
                  emit_acc = emit_acc + emit_rate;
                  units    = emit_acc[16:8];
                  emit_acc = {9'd0, emit_acc[7:0]};
               end
               // step and compact in pool order
               w = 0;
               for (int i = 0; i < pool_count; i++) begin
                  vx  = sat(int'(vel_x[i]) + int'(accel_x), -32768, 32767);
                  vy  = sat(int'(vel_y[i]) + int'(accel_y), -32768, 32767);
                  px  = sat(int'(pos_x[i]) + vx, -8388608, 8388607);
                  py  = sat(int'(pos_y[i]) + vy, -8388608, 8388607);
                  lf  = life_left[i];
                  tot = life_total[i];
                  if (lf > 1) begin
                     lf--;
                     elapsed = tot >= lf ? tot - lf : 0;
                     c = interp(color_begin, color_final, elapsed, tot, look_color[i]);
                     s = interp(size_begin, size_final, elapsed, tot, look_size[i]);
                     pos_x[w]      = 24'(px);
                     pos_y[w]      = 24'(py);
                     vel_x[w]      = 16'(vx);
                     vel_y[w]      = 16'(vy);
                     life_left[w]  = 16'(lf);
                     life_total[w] = 16'(tot);
                     look_color[w] = c;
                     look_size[w]  = s;
                     w++;
                  end
               end
               pool_count = w;
               req = units < DEPTH - w ? units : DEPTH - w;
               for (int i = 0; i < pool_count; i++) begin
                  r.kind          = 0;
                  r.pixel_x       = 16'(int'(pos_x[i]) / 256);
                  r.pixel_y       = 16'(int'(pos_y[i]) / 256);
                  r.color         = look_color[i];
                  r.size          = look_size[i];
                  r.live_count    = 6'(pool_count);
                  r.spawn_request = 6'(req);
                  r.accepted      = 0;
                  r.last          = 0;
                  owed_beats.push_back(r);
               end
            end
         endcase
         r.kind          = 1;
         r.pixel_x       = '0;
         r.pixel_y       = '0;
         r.color         = '0;
         r.size          = '0;
         r.live_count    = 6'(pool_count);
         r.spawn_request = 6'(req);
         r.accepted      = took;
         r.last          = 1;
         owed_beats.push_back(r);
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $time, what);
         errors++;
      endtask

      task check_beat(pixel_rec_type got);
         pixel_rec_type e;
         beats_checked++;
         if (owed_beats.size() == 0) begin
            report("result beat with nothing expected");
            return;
         end
         e = owed_beats.pop_front();
         if (got.kind != e.kind)
            report($sformatf("kind %0d, want %0d", got.kind, e.kind));
         if (got.pixel_x != e.pixel_x)
            report($sformatf("pixel_x %h, want %h", got.pixel_x, e.pixel_x));
         if (got.pixel_y != e.pixel_y)
            report($sformatf("pixel_y %h, want %h", got.pixel_y, e.pixel_y));
         if (got.color != e.color)
            report($sformatf("color %0d, want %0d", got.color, e.color));
         if (got.size != e.size)
            report($sformatf("size %0d, want %0d", got.size, e.size));
         if (got.live_count != e.live_count)
            report($sformatf("live_count %0d, want %0d", got.live_count, e.live_count));
         if (got.spawn_request != e.spawn_request)
            report($sformatf("spawn_request %0d, want %0d", got.spawn_request,
                             e.spawn_request));
         if (got.accepted != e.accepted)
            report($sformatf("accepted %0d, want %0d", got.accepted, e.accepted));
         if (got.last != e.last)
            report($sformatf("last %0d, want %0d", got.last, e.last));
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;   // pos_x, pos_y, vel_x, vel_y, life_ticks
   logic [1:0]  req_tuser = '0;   // command
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [63:0] rsp_tdata;        // pixel_x, pixel_y, color, size, live_count,
                                  // spawn_request, accepted, zero pad
   logic [0:0]  rsp_tuser;        // kind
   logic        rsp_tlast;
   logic        csr_we = 0;
   logic [2:0]  csr_index = '0;
   logic [15:0] csr_wdata = '0;

   particle_scoreboard pool_model = new();
   int            send_idle_pct = 0;   // chance per cycle that the sender waits
   int            rsp_stall_pct = 0;   // chance per cycle that the receiver stalls
   int            hold_requests = 0;   // bumped by the stimulus to ask for a long hold
   int            hold_seen = 0;
   int            hold_left = 0;
   pixel_rec_type got_beat;

   particle_pool_physics_step dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // receiver: checks every accepted beat, then decides tready for the next cycle
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         got_beat.kind          = rsp_tuser[0];
         got_beat.pixel_x       = rsp_tdata[15:0];
         got_beat.pixel_y       = rsp_tdata[31:16];
         got_beat.color         = rsp_tdata[39:32];
         got_beat.size          = rsp_tdata[47:40];
         got_beat.live_count    = rsp_tdata[53:48];
         got_beat.spawn_request = rsp_tdata[59:54];
         got_beat.accepted      = rsp_tdata[60];
         got_beat.last          = rsp_tlast;
         pool_model.check_beat(got_beat);
      end
      // a long hold-off is counted here so the sender can keep pushing meanwhile
      if (hold_requests != hold_seen) begin
         hold_seen = hold_requests;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= $urandom_range(0, 99) >= rsp_stall_pct;
      end
   end

   // one input beat; tvalid stays high into the next call unless a gap is taken
   task send(cmd_type cmd, logic [15:0] px, logic [15:0] py, logic [15:0] vx,
             logic [15:0] vy, logic [15:0] life);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {life, vy, vx, py, px};
      do @(posedge clock); while (!req_tready);
      pool_model.note_input(cmd, {life, vy, vx, py, px});
   endtask

   task send_cmd(cmd_type cmd);
      send(cmd, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   // stop sending and wait until every owed beat has come back
   task wait_drain();
      req_tvalid <= 1'b0;
      while (pool_model.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // writes all registers back to back; only called once the block is drained
   task write_regs(logic [15:0] ax, logic [15:0] ay, logic [7:0] cb, logic [7:0] cf,
                   logic [7:0] sb, logic [7:0] sf, logic [15:0] rate);
      logic [15:0] vals[7];
      vals = '{ax, ay, {8'd0, cb}, {8'd0, cf}, {8'd0, sb}, {8'd0, sf}, rate};
      for (int i = 0; i < 7; i++) begin
         csr_we    <= 1'b1;
         csr_index <= 3'(i);
         csr_wdata <= vals[i];
         pool_model.set_reg(3'(i), vals[i]);
         @(posedge clock);
      end
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // mostly nearby positions and short lives so the pool churns; full range now and then
   task rand_item();
      int          pick;
      logic [15:0] px, py, vx, vy, life;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         send_cmd(CMD_TICK);
      end else if (pick < 88) begin
         px = $urandom_range(0, 9) < 7 ? 16'($urandom_range(0, 400) - 200) : 16'($urandom);
         py = $urandom_range(0, 9) < 7 ? 16'($urandom_range(0, 400) - 200) : 16'($urandom);
         vx = $urandom_range(0, 9) < 7 ? 16'($urandom_range(0, 1024) - 512) : 16'($urandom);
         vy = $urandom_range(0, 9) < 7 ? 16'($urandom_range(0, 1024) - 512) : 16'($urandom);
         life = $urandom_range(0, 19) == 0 ? 16'($urandom) : 16'($urandom_range(0, 12));
         send(CMD_SPAWN, px, py, vx, vy, life);
      end else if (pick < 94) begin
         send_cmd(CMD_START);
      end else begin
         send_cmd(CMD_STOP);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset register values, position and velocity extremes, short lives
      send_cmd(CMD_START);
      send(CMD_SPAWN, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'hFFFF);
      send(CMD_SPAWN, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'd0);
      send(CMD_SPAWN, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1);
      send(CMD_SPAWN, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd2);
      send(CMD_SPAWN, 16'd100, -16'sd100, 16'd255, -16'sd256, 16'hAAAA);
      send_cmd(CMD_TICK);
      send_cmd(CMD_TICK);
      send(CMD_SPAWN, 16'd5, 16'd5, 16'd1, 16'd1, 16'h5555);
      send_cmd(CMD_TICK);
      send_cmd(CMD_STOP);
      send_cmd(CMD_TICK);
      wait_drain();
      // full-scale acceleration, widest color and size ramps, largest emission rate
      write_regs(16'h7FFF, 16'h8000, 8'd0, 8'd255, 8'd255, 8'd0, 16'hFFFF);
      send_cmd(CMD_START);
      send_cmd(CMD_TICK);
      send(CMD_SPAWN, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd4);
      send_cmd(CMD_TICK);
      send_cmd(CMD_TICK);
      wait_drain();
      // opposite extremes: equal endpoints keep stored look, emission off by zero rate
      write_regs(16'h8000, 16'h7FFF, 8'd77, 8'd77, 8'd9, 8'd9, 16'd0);
      send_cmd(CMD_TICK);
      send_cmd(CMD_TICK);
      wait_drain();

      // pressure: receiver holds off while spawns pile up past a full pool
      write_regs(16'd3, -16'sd3, 8'd10, 8'd200, 8'd40, 8'd2, 16'd300);
      hold_requests++;
      for (int i = 0; i < 36; i++)
         send(CMD_SPAWN, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom_range(3, 6)));
      send_cmd(CMD_START);
      send_cmd(CMD_TICK);
      wait_drain();
      for (int i = 0; i < 6; i++) send_cmd(CMD_TICK);

      // random phases, each with its own register setting and idling pattern
      for (int ph = 0; ph < 4; ph++) begin
         wait_drain();
         case (ph)
            0: write_regs(16'($urandom_range(0, 40) - 20), 16'($urandom_range(0, 40) - 20),
                          8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                          16'($urandom_range(1, 700)));
            1: write_regs(16'h7FFF, 16'h7FFF, 8'd255, 8'd0, 8'd0, 8'd255, 16'hFFFF);
            2: write_regs(16'h8000, 16'h8000, 8'd0, 8'd0, 8'd255, 8'd255, 16'd1);
            default: write_regs(16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom),
                                8'($urandom), 8'($urandom), 16'($urandom_range(0, 2000)));
         endcase
         send_idle_pct = (ph == 1) ? 55 : (ph == 3) ? 24 : 0;
         rsp_stall_pct = (ph == 2) ? 55 : (ph == 3) ? 24 : 0;
         send_cmd(CMD_START);
         for (int i = 0; i < 88; i++) rand_item();
      end

      wait_drain();
      repeat (100) @(posedge clock);
      if (pool_model.pending() != 0)
         pool_model.report("expected beat never arrived");
      $display("covered %0d ticks, %0d spawns taken, %0d dropped on a full pool",
               pool_model.ticks, pool_model.spawns_taken, pool_model.spawns_dropped);
      $display("%0d result beats checked", pool_model.beats_checked);
      if (pool_model.errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // hang guard
   initial begin
      #20ms;
      $display("timeout waiting on the block");
      $display("end of test: mismatches");
      $finish;
   end

endmodule
